### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication under the active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Non-overlapping implication under the active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/cnfup_pkg.sv
// ----------------------------------------------------------------------------
// cnfup_pkg
// Types and constants of the unit propagation block.
// ----------------------------------------------------------------------------
package cnfup_pkg;

    localparam int VAR_SLOTS = 32;
    localparam int VW        = 5;
    localparam int EW        = VW + 1;
    localparam int OUT_DW    = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNSAT = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_CL_RD,
        S_CL_CHK,
        S_LIT_RD,
        S_LIT_CHK,
        S_FIND_RD,
        S_FIND_CHK,
        S_CNT_RD,
        S_CNT_ACC,
        S_OUT_LOAD,
        S_OUT_WAIT
    } state_t;

endpackage

### sv/cnfup_ram.sv
// ----------------------------------------------------------------------------
// cnfup_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module cnfup_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/cnf_unit_propagation.sv
// ----------------------------------------------------------------------------
// cnf_unit_propagation
// Loads a CNF formula literal by literal, runs unit propagation at formula
// end and reports the assignment of every variable.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                      | tuser                  | tlast
//  s_*     | in  | var_index, positive        | has_literal, clause_end| formula_end
//  m_*     | out | out_var, assigned, value,  | -                      | last
//          |     | status, clauses_left       |                        |
//
//  Literal items are taken while the block is idle. A formula-end item runs
//  the propagation sequencer: per dequeued variable every kept clause is
//  walked and its literals are read from the literal memory, then the kept
//  clauses still unsatisfied are counted and one result per variable is sent.
//  s_tready is low from formula end until the last result is taken; results
//  hold while m_tready is low. Reset clears all control state; memories are
//  only read below the clause count of the current formula.
// ----------------------------------------------------------------------------
module cnf_unit_propagation
    import cnfup_pkg::*;
#(
    parameter int MAX_VARS    = 32,
    parameter int MAX_CLAUSES = 64,
    parameter int MAX_LITS    = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,  // [4:0] var_index, [5] positive, [7:6] zero
    input  logic [1:0]        s_tuser,  // [0] has_literal, [1] clause_end
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,  // [4:0] out_var, [5] assigned, [6] value,
                                        // [8:7] status, [15:9] clauses_left
    output logic              m_tlast
);

    localparam int VAR_LIMIT = (MAX_VARS < VAR_SLOTS) ? MAX_VARS : VAR_SLOTS;
    localparam int LW        = $clog2(MAX_LITS + 1);
    localparam int IW        = $clog2(MAX_LITS);
    localparam int CCW       = $clog2(MAX_CLAUSES + 1);
    localparam int CAW       = $clog2(MAX_CLAUSES);
    localparam int SDEPTH    = (MAX_CLAUSES + 1) * MAX_LITS;
    localparam int SAW       = $clog2(SDEPTH);
    localparam int QW        = $clog2(VAR_SLOTS + 1);

    state_t             state_reg, state_next;
    logic [LW-1:0]      fill_reg, fill_next;
    logic               taut_reg, taut_next;
    logic [CCW-1:0]     cc_reg, cc_next;
    logic [CCW-1:0]     c_reg, c_next;
    logic [LW-1:0]      idx_reg, idx_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      open_reg, open_next;
    logic [VW-1:0]      pv_reg, pv_next;
    logic               pval_reg, pval_next;
    logic [VAR_SLOTS-1:0] avalid_reg, avalid_next;
    logic [VAR_SLOTS-1:0] avalue_reg, avalue_next;
    logic [VAR_SLOTS-1:0] proc_reg, proc_next;
    logic [VW-1:0]      queue_reg [VAR_SLOTS];
    logic [QW-1:0]      qhead_reg, qhead_next;
    logic [QW-1:0]      qtail_reg, qtail_next;
    logic               unsat_reg, unsat_next;
    logic               ovf_reg, ovf_next;
    logic [6:0]         left_reg, left_next;
    logic [VW-1:0]      oi_reg, oi_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_DW-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic [EW-1:0]      row_reg [MAX_LITS];

    // Input item decode
    logic           s_hs;
    logic           in_has;
    logic [VW-1:0]  in_var;
    logic           in_pos;
    logic           in_ce;
    logic           in_fe;

    // Load path
    logic           var_ok;
    logic           any_match;
    logic           taut_hit;
    logic           add_ok;
    logic           ovf_add;
    logic [LW-1:0]  fill_n;
    logic           taut_n;
    logic [EW-1:0]  row0_n;
    logic           do_close;

    // Shared literal fix
    logic           fix_req;
    logic [VW-1:0]  fix_var;
    logic           fix_pol;
    logic           fix_clash;
    logic           fix_new;

    // Memory ports
    logic            lit_we;
    logic [SAW-1:0]  lit_waddr;
    logic [SAW-1:0]  lit_raddr;
    logic [EW-1:0]   lit_rd;
    logic            len_we;
    logic [LW-1:0]   len_rd;
    logic            open_we;
    logic [CAW-1:0]  open_waddr;
    logic [LW-1:0]   open_wdata;
    logic [LW-1:0]   open_rd;
    logic            live_we;
    logic [CAW-1:0]  live_waddr;
    logic            live_wdata;
    logic            live_rd;
    logic [CAW-1:0]  cl_raddr;
    logic [1:0]      status;

    assign s_hs   = s_tvalid && s_tready;
    assign in_has = s_tuser[0];
    assign in_ce  = s_tuser[1];
    assign in_var = s_tdata[VW-1:0];
    assign in_pos = s_tdata[VW];
    assign in_fe  = s_tlast;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign status = ovf_reg ? ST_OVF : (unsat_reg ? ST_UNSAT : ST_OK);

    // Merge, tautology and capacity checks for the open clause
    always_comb
    begin
        any_match = 1'b0;
        taut_hit  = 1'b0;
        for (int i = 0; i < MAX_LITS; i++)
        begin
            if ((LW'(i) < fill_reg) && (row_reg[i][EW-1:1] == in_var))
            begin
                any_match = 1'b1;
                if (row_reg[i][0] != in_pos)
                begin
                    taut_hit = 1'b1;
                end
            end
        end
        var_ok  = ({1'b0, in_var} < (VW+1)'(VAR_LIMIT));
        add_ok  = in_has && var_ok && !any_match && (fill_reg < LW'(MAX_LITS));
        ovf_add = in_has && (!var_ok || (!any_match && (fill_reg >= LW'(MAX_LITS))));
        fill_n  = fill_reg + LW'(add_ok);
        taut_n  = taut_reg || (in_has && var_ok && taut_hit);
        row0_n  = ((fill_reg == '0) && add_ok) ? {in_var, in_pos} : row_reg[0];
        do_close = in_ce || (in_fe && ((fill_n != '0) || taut_n));
    end

    // Select the literal to fix: a unit clause at load or a forced literal
    always_comb
    begin
        fix_req = 1'b0;
        fix_var = row0_n[EW-1:1];
        fix_pol = row0_n[0];
        case (state_reg)
            S_IDLE:
            begin
                fix_req = s_hs && do_close && !taut_n && (fill_n == LW'(1));
            end
            S_FIND_CHK:
            begin
                fix_var = lit_rd[EW-1:1];
                fix_pol = lit_rd[0];
                fix_req = (LW'(idx_reg) < len_reg) && !proc_reg[lit_rd[EW-1:1]];
            end
            default:
            begin
                fix_req = 1'b0;
            end
        endcase
        fix_clash = fix_req && avalid_reg[fix_var] && (avalue_reg[fix_var] != fix_pol);
        fix_new   = fix_req && !avalid_reg[fix_var];
    end

    // Memory addresses
    assign lit_waddr = SAW'(cc_reg) * SAW'(MAX_LITS) + SAW'(fill_reg);
    assign lit_raddr = SAW'(c_reg) * SAW'(MAX_LITS) + SAW'(idx_reg);
    assign lit_we    = (state_reg == S_IDLE) && s_hs && add_ok;
    assign cl_raddr  = c_reg[CAW-1:0];

    // Sequencer: next state, counters and flags
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        taut_next     = taut_reg;
        cc_next       = cc_reg;
        c_next        = c_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        open_next     = open_reg;
        pv_next       = pv_reg;
        pval_next     = pval_reg;
        avalid_next   = avalid_reg;
        avalue_next   = avalue_reg;
        proc_next     = proc_reg;
        qhead_next    = qhead_reg;
        qtail_next    = qtail_reg;
        unsat_next    = unsat_reg;
        ovf_next      = ovf_reg;
        left_next     = left_reg;
        oi_next       = oi_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        len_we        = 1'b0;
        open_we       = 1'b0;
        open_waddr    = cc_reg[CAW-1:0];
        open_wdata    = fill_n;
        live_we       = 1'b0;
        live_waddr    = cc_reg[CAW-1:0];
        live_wdata    = 1'b1;

        // Record a newly fixed literal and queue it
        if (fix_new)
        begin
            avalid_next[fix_var] = 1'b1;
            avalue_next[fix_var] = fix_pol;
            if (qtail_reg < QW'(VAR_SLOTS))
            begin
                qtail_next = qtail_reg + QW'(1);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_hs)
                begin
                    fill_next = fill_n;
                    taut_next = taut_n;
                    if (ovf_add)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (do_close)
                    begin
                        fill_next = '0;
                        taut_next = 1'b0;
                        if (!taut_n)
                        begin
                            if (fill_n == '0)
                            begin
                                unsat_next = 1'b1;
                            end
                            else if (fill_n == LW'(1))
                            begin
                                if (fix_clash)
                                begin
                                    unsat_next = 1'b1;
                                end
                            end
                            else if (cc_reg >= CCW'(MAX_CLAUSES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                len_we  = 1'b1;
                                open_we = 1'b1;
                                live_we = 1'b1;
                                cc_next = cc_reg + CCW'(1);
                            end
                        end
                    end
                    if (in_fe)
                    begin
                        c_next    = '0;
                        left_next = '0;
                        oi_next   = '0;
                        if (unsat_next || ovf_next)
                        begin
                            state_next = S_OUT_LOAD;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_POP:
            begin
                c_next = '0;
                if (qhead_reg == qtail_reg)
                begin
                    state_next = S_CNT_RD;
                end
                else
                begin
                    pv_next                 = queue_reg[qhead_reg[VW-1:0]];
                    pval_next               = avalue_reg[queue_reg[qhead_reg[VW-1:0]]];
                    proc_next[queue_reg[qhead_reg[VW-1:0]]] = 1'b1;
                    qhead_next              = qhead_reg + QW'(1);
                    state_next              = S_CL_RD;
                end
            end

            S_CL_RD:
            begin
                if (c_reg == cc_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_CL_CHK;
                end
            end

            S_CL_CHK:
            begin
                len_next  = len_rd;
                open_next = open_rd;
                idx_next  = '0;
                if (live_rd)
                begin
                    state_next = S_LIT_RD;
                end
                else
                begin
                    c_next     = c_reg + CCW'(1);
                    state_next = S_CL_RD;
                end
            end

            S_LIT_RD:
            begin
                if (idx_reg >= len_reg)
                begin
                    c_next     = c_reg + CCW'(1);
                    state_next = S_CL_RD;
                end
                else
                begin
                    state_next = S_LIT_CHK;
                end
            end

            S_LIT_CHK:
            begin
                if (lit_rd[EW-1:1] != pv_reg)
                begin
                    idx_next   = idx_reg + LW'(1);
                    state_next = S_LIT_RD;
                end
                else
                begin
                    c_next     = c_reg + CCW'(1);
                    state_next = S_CL_RD;
                    if (lit_rd[0] == pval_reg)
                    begin
                        // True literal: the clause is satisfied
                        live_we    = 1'b1;
                        live_waddr = cl_raddr;
                        live_wdata = 1'b0;
                    end
                    else if (open_reg != '0)
                    begin
                        // False literal: shorten, force the last open one
                        open_we    = 1'b1;
                        open_waddr = cl_raddr;
                        open_wdata = open_reg - LW'(1);
                        if (open_reg == LW'(2))
                        begin
                            c_next     = c_reg;
                            idx_next   = '0;
                            state_next = S_FIND_RD;
                        end
                    end
                end
            end

            S_FIND_RD:
            begin
                if (idx_reg >= len_reg)
                begin
                    c_next     = c_reg + CCW'(1);
                    state_next = S_CL_RD;
                end
                else
                begin
                    state_next = S_FIND_CHK;
                end
            end

            S_FIND_CHK:
            begin
                if (fix_clash)
                begin
                    unsat_next = 1'b1;
                    oi_next    = '0;
                    state_next = S_OUT_LOAD;
                end
                else if (fix_req)
                begin
                    c_next     = c_reg + CCW'(1);
                    state_next = S_CL_RD;
                end
                else
                begin
                    idx_next   = idx_reg + LW'(1);
                    state_next = S_FIND_RD;
                end
            end

            S_CNT_RD:
            begin
                if (c_reg == cc_reg)
                begin
                    oi_next    = '0;
                    state_next = S_OUT_LOAD;
                end
                else
                begin
                    state_next = S_CNT_ACC;
                end
            end

            S_CNT_ACC:
            begin
                left_next  = left_reg + 7'(live_rd);
                c_next     = c_reg + CCW'(1);
                state_next = S_CNT_RD;
            end

            S_OUT_LOAD:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {
                    (status == ST_OK) ? left_reg : 7'd0,
                    status,
                    (status == ST_OK) && avalid_reg[oi_reg] && avalue_reg[oi_reg],
                    (status == ST_OK) && avalid_reg[oi_reg],
                    oi_reg
                };
                m_tlast_next  = (oi_reg == VW'(VAR_LIMIT - 1));
                state_next    = S_OUT_WAIT;
            end

            S_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg)
                    begin
                        // Clear the formula state
                        fill_next   = '0;
                        taut_next   = 1'b0;
                        cc_next     = '0;
                        avalid_next = '0;
                        avalue_next = '0;
                        proc_next   = '0;
                        qhead_next  = '0;
                        qtail_next  = '0;
                        unsat_next  = 1'b0;
                        ovf_next    = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        oi_next    = oi_reg + VW'(1);
                        state_next = S_OUT_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            taut_reg     <= 1'b0;
            cc_reg       <= '0;
            c_reg        <= '0;
            idx_reg      <= '0;
            avalid_reg   <= '0;
            avalue_reg   <= '0;
            proc_reg     <= '0;
            qhead_reg    <= '0;
            qtail_reg    <= '0;
            unsat_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            oi_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            taut_reg     <= taut_next;
            cc_reg       <= cc_next;
            c_reg        <= c_next;
            idx_reg      <= idx_next;
            avalid_reg   <= avalid_next;
            avalue_reg   <= avalue_next;
            proc_reg     <= proc_next;
            qhead_reg    <= qhead_next;
            qtail_reg    <= qtail_next;
            unsat_reg    <= unsat_next;
            ovf_reg      <= ovf_next;
            oi_reg       <= oi_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        open_reg    <= open_next;
        pv_reg      <= pv_next;
        pval_reg    <= pval_next;
        left_reg    <= left_next;
        m_tdata_reg <= m_tdata_next;
        if (lit_we)
        begin
            row_reg[fill_reg[IW-1:0]] <= {in_var, in_pos};
        end
        if (fix_new && (qtail_reg < QW'(VAR_SLOTS)))
        begin
            queue_reg[qtail_reg[VW-1:0]] <= fix_var;
        end
    end

    // Literal store, one row per kept clause plus the row being loaded
    cnfup_ram #(
        .DEPTH (SDEPTH),
        .WIDTH (EW)
    ) u_lit_ram (
        .clk     (clk),
        .wr_en   (lit_we),
        .wr_addr (lit_waddr),
        .wr_data ({in_var, in_pos}),
        .rd_addr (lit_raddr),
        .rd_data (lit_rd)
    );

    // Clause length
    cnfup_ram #(
        .DEPTH (MAX_CLAUSES),
        .WIDTH (LW)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_we),
        .wr_addr (cc_reg[CAW-1:0]),
        .wr_data (fill_n),
        .rd_addr (cl_raddr),
        .rd_data (len_rd)
    );

    // Open literal count
    cnfup_ram #(
        .DEPTH (MAX_CLAUSES),
        .WIDTH (LW)
    ) u_open_ram (
        .clk     (clk),
        .wr_en   (open_we),
        .wr_addr (open_waddr),
        .wr_data (open_wdata),
        .rd_addr (cl_raddr),
        .rd_data (open_rd)
    );

    // Clause still unsatisfied
    cnfup_ram #(
        .DEPTH (MAX_CLAUSES),
        .WIDTH (1)
    ) u_live_ram (
        .clk     (clk),
        .wr_en   (live_we),
        .wr_addr (live_waddr),
        .wr_data (live_wdata),
        .rd_addr (cl_raddr),
        .rd_data (live_rd)
    );

endmodule

### sv/cnfup_checker.sv
// ----------------------------------------------------------------------------
// cnfup_checker
// Port-level checks of the unit propagation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnfup_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // Input is closed while results are offered
    `ASSERT_IMPLIES(a_no_overlap, clk, rst_n, m_tvalid, !s_tready)

    // A stalled result holds
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A failed formula reports no assignment and no clause count
    `ASSERT_IMPLIES(a_fail_blank, clk, rst_n, m_tvalid && (m_tdata[8:7] != 2'd0),
        (m_tdata[6:5] == 2'd0) && (m_tdata[15:9] == 7'd0))

    // The block reopens its input after the last result
    `ASSERT_NEXT(a_reopen, clk, rst_n, m_tvalid && m_tready && m_tlast,
        !m_tvalid && s_tready)

endmodule

bind cnf_unit_propagation cnfup_checker u_cnfup_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
